### src/tcw_pkg.sv
package tcw_pkg;

    localparam int unsigned MAX_WINDOW  = 64;
    localparam int unsigned WIN_W       = 7;
    localparam int unsigned SEQ_W       = 32;
    localparam int unsigned DUP_W       = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    localparam logic [SEQ_W-1:0] SEQ_RESET    = SEQ_W'(1);
    localparam logic [WIN_W-1:0] WIN_RESET    = WIN_W'(1);
    localparam logic [WIN_W-1:0] THR_RESET    = WIN_W'(8);
    localparam logic [DUP_W-1:0] DUP_RESET    = DUP_W'(1);
    localparam logic [DUP_W-1:0] DUP_TRIGGER  = DUP_W'(3);
    localparam logic [SEQ_W-1:0] RESENT_RESET = '1;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_ACK  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_RETX    = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    typedef enum logic {
        MODE_SLOW_START = 1'b0,
        MODE_AVOID      = 1'b1
    } mode_t;

    typedef struct packed {
        op_t               op;
        logic [SEQ_W-1:0]  ack_value;
    } cmd_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic  valid;
        cmd_t  cmd;
    } cmd_head_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [WIN_W-1:0]  window;
        logic [WIN_W-1:0]  threshold;
        mode_t             mode;
        logic              round_done;
        logic              last;
    } res_t;

endpackage

### src/tcw_in_if.sv
interface tcw_in_if;
    logic                valid;
    logic                ready;
    logic                func;
    logic signed [31:0]  ack_value;

    modport source (
        output valid,
        output func,
        output ack_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  ack_value,
        output ready
    );
endinterface

### src/tcw_out_if.sv
interface tcw_out_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic signed [31:0]  seq_number;
    logic [6:0]          window;
    logic [6:0]          threshold;
    logic                mode;
    logic                round_done;
    logic                last;

    modport source (
        output valid,
        output kind,
        output seq_number,
        output window,
        output threshold,
        output mode,
        output round_done,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  seq_number,
        input  window,
        input  threshold,
        input  mode,
        input  round_done,
        input  last,
        output ready
    );
endinterface

### src/tcp_congestion_window_sender.sv
// Window-based sender with slow start, congestion avoidance and retransmit on the
// third identical ack. A send request (func 0) produces one data segment per cycle
// while rsp is not stalled, window transfers in all (1 to 64), counted out by the
// burst counter in the back end; an ack (func 1) produces exactly one result.
// Every result sits in an output register, and a two-entry command queue in front
// lets req take new items while a burst is running or rsp is stalled; the block is
// ready right after reset.
module tcp_congestion_window_sender (
    input  logic        clk,
    input  logic        rst_n,
    tcw_in_if.sink      req,
    tcw_out_if.source   rsp
);

    tcw_pkg::cmd_head_t  head;
    logic                cmd_pop;

    tcw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cmd_pop (cmd_pop),
        .head    (head)
    );

    tcw_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .cmd_pop (cmd_pop),
        .rsp     (rsp)
    );

endmodule

### src/tcw_front.sv
module tcw_front (
    input  logic                clk,
    input  logic                rst_n,
    tcw_in_if.sink              req,
    input  logic                cmd_pop,
    output tcw_pkg::cmd_head_t  head
);

    tcw_pkg::cmd_t                   q_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tcw_pkg::QCNT_W-1:0]      count_reg;
    logic [tcw_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [tcw_pkg::QCNT_W-1:0]      count_next;
    logic                            push;
    tcw_pkg::cmd_t                   cmd_in;

    assign req.ready = (count_reg != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;

    // classify the incoming transfer
    always_comb
    begin
        cmd_in.op        = req.func ? tcw_pkg::OP_ACK : tcw_pkg::OP_SEND;
        cmd_in.ack_value = req.ack_value;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tcw_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + tcw_pkg::QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, cmd_pop})
            2'b10:   count_next = count_reg + tcw_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - tcw_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill count");

endmodule

### src/tcw_back.sv
module tcw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::cmd_head_t  head,
    output logic                cmd_pop,
    tcw_out_if.source           rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    localparam logic [tcw_pkg::WIN_W-1:0] WIN_ONE = tcw_pkg::WIN_W'(1);
    localparam logic [tcw_pkg::WIN_W-1:0] WIN_MAX = tcw_pkg::WIN_W'(tcw_pkg::MAX_WINDOW);
    localparam logic [tcw_pkg::WIN_W:0]   GROW_MAX = (tcw_pkg::WIN_W + 1)'(tcw_pkg::MAX_WINDOW);

    state_t                          state_reg,       state_next;
    logic [tcw_pkg::WIN_W-1:0]       send_left_reg,   send_left_next;
    logic [tcw_pkg::SEQ_W-1:0]       next_seq_reg,    next_seq_next;
    logic [tcw_pkg::WIN_W-1:0]       cur_window_reg,  cur_window_next;
    logic [tcw_pkg::WIN_W-1:0]       cur_thr_reg,     cur_thr_next;
    tcw_pkg::mode_t                  cur_mode_reg,    cur_mode_next;
    logic [tcw_pkg::SEQ_W-1:0]       prev_ack_reg,    prev_ack_next;
    logic [tcw_pkg::DUP_W-1:0]       dup_count_reg,   dup_count_next;
    logic [tcw_pkg::SEQ_W-1:0]       last_resent_reg, last_resent_next;
    logic [tcw_pkg::WIN_W-1:0]       acks_left_reg,   acks_left_next;
    logic                            rsp_valid_reg,   rsp_valid_next;
    tcw_pkg::res_t                   res_reg,         res_next;

    logic                            out_free;
    logic [tcw_pkg::WIN_W-1:0]       send_n;
    logic                            is_dup;
    logic [tcw_pkg::DUP_W-1:0]       dup_inc;
    logic                            retx;
    logic [tcw_pkg::WIN_W-1:0]       acks_dec;
    logic [tcw_pkg::WIN_W-1:0]       half_win;
    logic [tcw_pkg::WIN_W-1:0]       retx_thr;
    tcw_pkg::mode_t                  close_mode;
    logic [tcw_pkg::WIN_W:0]         grown;
    logic [tcw_pkg::WIN_W-1:0]       close_window;

    assign out_free = !rsp_valid_reg || rsp.ready;

    // ack classification and window arithmetic
    always_comb
    begin
        if (cur_window_reg == '0)
            send_n = WIN_ONE;
        else if (cur_window_reg > WIN_MAX)
            send_n = WIN_MAX;
        else
            send_n = cur_window_reg;

        is_dup   = (head.cmd.ack_value == prev_ack_reg)
                   && (head.cmd.ack_value != last_resent_reg);
        dup_inc  = dup_count_reg + tcw_pkg::DUP_W'(1);
        retx     = is_dup && (dup_inc == tcw_pkg::DUP_TRIGGER);
        acks_dec = acks_left_reg - WIN_ONE;
        half_win = cur_window_reg >> 1;
        retx_thr = (half_win == '0) ? WIN_ONE : half_win;

        close_mode = (cur_window_reg >= cur_thr_reg) ? tcw_pkg::MODE_AVOID : cur_mode_reg;
        if (close_mode == tcw_pkg::MODE_SLOW_START)
            grown = {cur_window_reg, 1'b0};
        else
            grown = {1'b0, cur_window_reg} + (tcw_pkg::WIN_W + 1)'(1);
        close_window = (grown > GROW_MAX) ? WIN_MAX : grown[tcw_pkg::WIN_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        send_left_next   = send_left_reg;
        next_seq_next    = next_seq_reg;
        cur_window_next  = cur_window_reg;
        cur_thr_next     = cur_thr_reg;
        cur_mode_next    = cur_mode_reg;
        prev_ack_next    = prev_ack_reg;
        dup_count_next   = dup_count_reg;
        last_resent_next = last_resent_reg;
        acks_left_next   = acks_left_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        res_next         = res_reg;
        cmd_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    cmd_pop             = 1'b1;
                    rsp_valid_next      = 1'b1;
                    res_next.seq_number = '0;
                    res_next.round_done = 1'b0;
                    res_next.last       = 1'b1;
                    res_next.window     = cur_window_reg;
                    res_next.threshold  = cur_thr_reg;
                    res_next.mode       = cur_mode_reg;
                    if (head.cmd.op == tcw_pkg::OP_SEND)
                    begin
                        // first segment of the round goes out right away
                        acks_left_next      = send_n;
                        res_next.kind       = tcw_pkg::KIND_DATA;
                        res_next.seq_number = next_seq_reg;
                        res_next.last       = (send_n == WIN_ONE);
                        next_seq_next       = next_seq_reg + tcw_pkg::SEQ_W'(1);
                        if (send_n != WIN_ONE)
                        begin
                            state_next     = ST_SEND;
                            send_left_next = send_n - WIN_ONE;
                        end
                    end
                    else if (acks_left_reg == '0)
                    begin
                        res_next.kind = tcw_pkg::KIND_IGNORED;
                    end
                    else if (retx)
                    begin
                        // triple duplicate: fall back to a window of one
                        cur_thr_next        = retx_thr;
                        cur_window_next     = WIN_ONE;
                        cur_mode_next       = tcw_pkg::MODE_SLOW_START;
                        dup_count_next      = '0;
                        last_resent_next    = prev_ack_reg;
                        res_next.kind       = tcw_pkg::KIND_RETX;
                        res_next.seq_number = prev_ack_reg;
                        res_next.window     = WIN_ONE;
                        res_next.threshold  = retx_thr;
                        res_next.mode       = tcw_pkg::MODE_SLOW_START;
                    end
                    else
                    begin
                        acks_left_next = acks_dec;
                        res_next.kind  = tcw_pkg::KIND_STATUS;
                        if (is_dup)
                        begin
                            dup_count_next = dup_inc;
                        end
                        else
                        begin
                            dup_count_next = tcw_pkg::DUP_RESET;
                            prev_ack_next  = head.cmd.ack_value;
                        end
                        if (acks_dec == '0)
                        begin
                            cur_mode_next       = close_mode;
                            cur_window_next     = close_window;
                            res_next.mode       = close_mode;
                            res_next.window     = close_window;
                            res_next.round_done = 1'b1;
                        end
                    end
                end
            end

            ST_SEND:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    res_next.kind       = tcw_pkg::KIND_DATA;
                    res_next.seq_number = next_seq_reg;
                    res_next.window     = cur_window_reg;
                    res_next.threshold  = cur_thr_reg;
                    res_next.mode       = cur_mode_reg;
                    res_next.round_done = 1'b0;
                    res_next.last       = (send_left_reg == WIN_ONE);
                    next_seq_next       = next_seq_reg + tcw_pkg::SEQ_W'(1);
                    send_left_next      = send_left_reg - WIN_ONE;
                    if (send_left_reg == WIN_ONE)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            send_left_reg   <= '0;
            next_seq_reg    <= tcw_pkg::SEQ_RESET;
            cur_window_reg  <= tcw_pkg::WIN_RESET;
            cur_thr_reg     <= tcw_pkg::THR_RESET;
            cur_mode_reg    <= tcw_pkg::MODE_SLOW_START;
            prev_ack_reg    <= '0;
            dup_count_reg   <= tcw_pkg::DUP_RESET;
            last_resent_reg <= tcw_pkg::RESENT_RESET;
            acks_left_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            send_left_reg   <= send_left_next;
            next_seq_reg    <= next_seq_next;
            cur_window_reg  <= cur_window_next;
            cur_thr_reg     <= cur_thr_next;
            cur_mode_reg    <= cur_mode_next;
            prev_ack_reg    <= prev_ack_next;
            dup_count_reg   <= dup_count_next;
            last_resent_reg <= last_resent_next;
            acks_left_reg   <= acks_left_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.kind       = res_reg.kind;
    assign rsp.seq_number = $signed(res_reg.seq_number);
    assign rsp.window     = res_reg.window;
    assign rsp.threshold  = res_reg.threshold;
    assign rsp.mode       = res_reg.mode;
    assign rsp.round_done = res_reg.round_done;
    assign rsp.last       = res_reg.last;

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_window_reg != '0 && cur_window_reg <= WIN_MAX && cur_thr_reg != '0)
        else $error("window or threshold out of range");

    a_send_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEND |-> send_left_reg != '0 && acks_left_reg != '0)
        else $error("segment burst running with nothing left to send");

    a_retx_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && res_reg.kind == tcw_pkg::KIND_RETX
            |-> res_reg.window == WIN_ONE && res_reg.mode == tcw_pkg::MODE_SLOW_START
                && res_reg.last)
        else $error("retransmit result without window collapse");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> head.valid && state_reg == ST_IDLE)
        else $error("command taken from an empty queue or mid burst");

endmodule
